// ----- hdl/mcs_pkg.sv -----
package mcs_pkg;

    localparam int NOTE_LENGTH_DEF      = 8000;
    localparam int MELODY_LENGTH_DEF    = 16;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    localparam int RUN_W      = 17;
    localparam int GAIN_W     = 14;
    localparam int OFFSET_W   = 13;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int MUL_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASS_GAIN  = 2'd2;

    localparam logic [RUN_W-1:0]  RUN_LENGTH_RST = 17'd96000;
    localparam logic [GAIN_W-1:0] LEAD_GAIN_RST  = 14'd7200;
    localparam logic [GAIN_W-1:0] BASS_GAIN_RST  = 14'd2400;

    // quarter-wave polynomial, q30
    localparam logic [31:0] SIN_A9     = 32'd172272;
    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [32:0] Q15_HALF   = 33'd16384;
    localparam logic [14:0] SINE_MAX   = 15'h7fff;
    localparam logic [15:0] ENV_ONE    = 16'h8000;
    localparam logic [31:0] ATT_SCALE  = 32'd819200;
    localparam logic [31:0] REL_SCALE  = 32'd1638400;

    typedef struct packed {
        logic [31:0]         inc;
        logic [RUN_W-1:0]    position;
        logic [OFFSET_W-1:0] offset;
        logic [GAIN_W-1:0]   lead_gain;
        logic [GAIN_W-1:0]   bass_gain;
    } mcs_job_t;

    function automatic logic [31:0] horner_coef(input logic [1:0] idx);
        logic [31:0] c;
        case (idx)
            2'd0:    c = 32'd5026995;
            2'd1:    c = 32'd85569306;
            2'd2:    c = 32'd693598668;
            default: c = 32'd1686629713;
        endcase
        return c;
    endfunction

    // q0.32 phase increments at 16 kHz for the melody
    function automatic logic [31:0] melody_inc(input logic [3:0] idx);
        logic [31:0] inc;
        case (idx)
            4'd0:    inc = 32'd140459156;
            4'd1:    inc = 32'd176967447;
            4'd2:    inc = 32'd210450947;
            4'd3:    inc = 32'd265151578;
            4'd4:    inc = 32'd236223201;
            4'd5:    inc = 32'd210450947;
            4'd6:    inc = 32'd176967447;
            4'd7:    inc = 32'd140459156;
            4'd8:    inc = 32'd157660072;
            4'd9:    inc = 32'd187490479;
            4'd10:   inc = 32'd236223201;
            4'd11:   inc = 32'd280918312;
            4'd12:   inc = 32'd265151578;
            4'd13:   inc = 32'd210450947;
            4'd14:   inc = 32'd176967447;
            default: inc = 32'd140459156;
        endcase
        return inc;
    endfunction

endpackage

// ----- hdl/melody_chime_synth.sv -----
// Chime sample generator. Each word taken on the s_ channel asks for one
// 16-bit PCM sample; s_stop_request set ends the run at once and yields a
// zero sample with m_last set. Each word on the m_ channel carries m_sample
// and m_last; m_last marks the end of a run, after which the sample
// position starts again from zero.
// A sample word makes 18 passes through the shared 32x32 multiplier
// (phase product, envelope division and correction, two sine polynomials,
// two gains, final scaling); the core then registers its done flag, the
// block moves to its done state and, once the output register is free,
// loads it and raises m_valid. A stop word skips the core: the block goes
// to its done state and loads a zero sample the same way.
// One word is in work at a time; s_ready rises again at the edge that loads
// the result into the output register.
// The output register holds a finished word while m_ready is low; the block
// takes and computes the next word meanwhile and waits only to hand it over.
// Synchronous active-low reset returns run_length, lead_gain and bass_gain to
// their defaults, clears the sample position and empties the output.
// Configuration writes take effect at once; the user makes them while idle (not enforced by the block).
module melody_chime_synth
    import mcs_pkg::*;
#(
    parameter int NOTE_LENGTH      = NOTE_LENGTH_DEF,
    parameter int MELODY_LENGTH    = MELODY_LENGTH_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_stop_request,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample,
    output logic                       m_last,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int SLOT_W = (MELODY_LENGTH > 1) ? $clog2(MELODY_LENGTH) : 1;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_BUSY = 3'b010,
        T_DONE = 3'b100
    } top_state_t;

    top_state_t           state_reg, state_next;
    logic [RUN_W-1:0]     run_length_reg, run_length_next;
    logic [GAIN_W-1:0]    lead_gain_reg, lead_gain_next;
    logic [GAIN_W-1:0]    bass_gain_reg, bass_gain_next;
    logic [RUN_W-1:0]     position_reg, position_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [OFFSET_W-1:0]  offset_reg, offset_next;
    logic                 stop_reg, stop_next;
    logic                 m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]  m_sample_reg, m_sample_next;
    logic                 m_last_reg, m_last_next;

    logic                 in_accept;
    logic                 core_start;
    logic                 core_done;
    logic [SAMPLE_W-1:0]  core_sample;
    mcs_job_t             job;
    logic                 out_free;
    logic [RUN_W:0]       pos_plus1;
    logic                 end_run;
    logic [OFFSET_W:0]    offset_plus1;
    logic [SLOT_W:0]      slot_plus1;

    assign in_accept  = s_valid && (state_reg == T_IDLE);
    assign core_start = in_accept && !s_stop_request;
    assign out_free   = !m_valid_reg || m_ready;

    assign pos_plus1    = {1'b0, position_reg} + 1'b1;
    assign end_run      = pos_plus1 >= {1'b0, run_length_reg};
    assign offset_plus1 = {1'b0, offset_reg} + 1'b1;
    assign slot_plus1   = {1'b0, slot_reg} + 1'b1;

    assign job.inc       = melody_inc(4'(slot_reg));
    assign job.position  = position_reg;
    assign job.offset    = offset_reg;
    assign job.lead_gain = lead_gain_reg;
    assign job.bass_gain = bass_gain_reg;

    mcs_core #(
        .NOTE_LENGTH      (NOTE_LENGTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (core_start),
        .job     (job),
        .done    (core_done),
        .sample  (core_sample)
    );

    always_comb begin
        state_next      = state_reg;
        run_length_next = run_length_reg;
        lead_gain_next  = lead_gain_reg;
        bass_gain_next  = bass_gain_reg;
        position_next   = position_reg;
        slot_next       = slot_reg;
        offset_next     = offset_reg;
        stop_next       = stop_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_sample_next   = m_sample_reg;
        m_last_next     = m_last_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RUN_LENGTH: run_length_next = cfg_wr_data[RUN_W-1:0];
                CFG_LEAD_GAIN:  lead_gain_next  = cfg_wr_data[GAIN_W-1:0];
                CFG_BASS_GAIN:  bass_gain_next  = cfg_wr_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end

        case (state_reg)
            T_IDLE: begin
                if (in_accept) begin
                    stop_next  = s_stop_request;
                    state_next = s_stop_request ? T_DONE : T_BUSY;
                end
            end
            T_BUSY: begin
                if (core_done) begin
                    state_next = T_DONE;
                end
            end
            T_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = stop_reg ? '0 : core_sample;
                    m_last_next   = stop_reg || end_run;
                    state_next    = T_IDLE;
                    if (stop_reg || end_run) begin
                        position_next = '0;
                        slot_next     = '0;
                        offset_next   = '0;
                    end else begin
                        position_next = pos_plus1[RUN_W-1:0];
                        if (offset_plus1 >= (OFFSET_W+1)'(NOTE_LENGTH)) begin
                            offset_next = '0;
                            if (slot_plus1 >= (SLOT_W+1)'(MELODY_LENGTH)) begin
                                slot_next = '0;
                            end else begin
                                slot_next = slot_plus1[SLOT_W-1:0];
                            end
                        end else begin
                            offset_next = offset_plus1[OFFSET_W-1:0];
                        end
                    end
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= T_IDLE;
            run_length_reg <= RUN_LENGTH_RST;
            lead_gain_reg  <= LEAD_GAIN_RST;
            bass_gain_reg  <= BASS_GAIN_RST;
            position_reg   <= '0;
            slot_reg       <= '0;
            offset_reg     <= '0;
            stop_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            run_length_reg <= run_length_next;
            lead_gain_reg  <= lead_gain_next;
            bass_gain_reg  <= bass_gain_next;
            position_reg   <= position_next;
            slot_reg       <= slot_next;
            offset_reg     <= offset_next;
            stop_reg       <= stop_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_sample_reg <= m_sample_next;
        m_last_reg   <= m_last_next;
    end

    assign s_ready  = (state_reg == T_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;
    assign m_last   = m_last_reg;

endmodule

// ----- hdl/mcs_mul.sv -----
module mcs_mul
    import mcs_pkg::*;
(
    input  logic                 aclk,
    input  logic [MUL_W-1:0]     mul_a,
    input  logic [MUL_W-1:0]     mul_b,
    output logic [2*MUL_W-1:0]   mul_p
);

    logic [2*MUL_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= mul_a * mul_b;
    end

    assign mul_p = p_reg;

endmodule

// ----- hdl/mcs_core.sv -----
module mcs_core
    import mcs_pkg::*;
#(
    parameter int NOTE_LENGTH      = NOTE_LENGTH_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  mcs_job_t            job,
    output logic                done,
    output logic [SAMPLE_W-1:0] sample
);

    localparam int TBL_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam longint unsigned TWO32 = 64'h1_0000_0000;
    localparam logic [19:0] ATT_LIMIT = 20'(2 * NOTE_LENGTH);
    localparam logic [19:0] REL_LIMIT = 20'(41 * NOTE_LENGTH);
    localparam logic [31:0] ATT_DIV   = 32'(2 * NOTE_LENGTH);
    localparam logic [31:0] REL_DIV   = 32'(9 * NOTE_LENGTH);
    localparam logic [31:0] ATT_RECIP = 32'(TWO32 / (2 * NOTE_LENGTH));
    localparam logic [31:0] REL_RECIP = 32'(TWO32 / (9 * NOTE_LENGTH));

    typedef enum logic [8:0] {
        C_IDLE   = 9'b000000001,
        C_PROD   = 9'b000000010,
        C_RECIP  = 9'b000000100,
        C_CORR   = 9'b000001000,
        C_SQUARE = 9'b000010000,
        C_HORNER = 9'b000100000,
        C_POLY   = 9'b001000000,
        C_GAIN   = 9'b010000000,
        C_SCALE  = 9'b100000000
    } core_state_t;

    core_state_t          state_reg, state_next;
    logic                 phase_reg, phase_next;
    logic [1:0]           hcnt_reg, hcnt_next;
    logic                 sel_reg, sel_next;
    logic [32:0]          prod_reg, prod_next;
    logic [15:0]          q0_reg, q0_next;
    logic [15:0]          env_reg, env_next;
    logic [30:0]          x2_reg, x2_next;
    logic [31:0]          t_reg, t_next;
    logic [14:0]          v_reg, v_next;
    logic signed [31:0]   mix_reg, mix_next;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic                 done_reg, done_next;

    logic [MUL_W-1:0]     op_a, op_b;
    logic [2*MUL_W-1:0]   mul_p;

    logic [31:0]          phase_w;
    logic [TBL_BITS-1:0]  tbl_k;
    logic [1:0]           quad;
    logic [29:0]          frac_r;
    logic [30:0]          x_w;

    logic [19:0]          off_x25, off_x50;
    logic                 att_region, rel_region;
    logic [31:0]          n_att, n_rel, div_n, div_d, div_r, rem;
    logic [15:0]          q0_inc;

    logic [GAIN_W-1:0]    gain_w;
    logic signed [31:0]   mix_abs, gain_term, mix_base;
    logic [32:0]          s_round;
    logic [17:0]          v_wide;
    logic [15:0]          scaled;

    mcs_mul u_mul (
        .aclk  (aclk),
        .mul_a (op_a),
        .mul_b (op_b),
        .mul_p (mul_p)
    );

    // sine table address from the lead or the octave-down phase
    assign phase_w = sel_reg ? prod_reg[32:1] : prod_reg[31:0];
    assign tbl_k   = phase_w[31 -: TBL_BITS];
    assign quad    = tbl_k[TBL_BITS-1 -: 2];
    assign frac_r  = {tbl_k[TBL_BITS-3:0], {(32 - TBL_BITS){1'b0}}};
    assign x_w     = quad[0] ? (Q30_ONE - {1'b0, frac_r}) : {1'b0, frac_r};

    // envelope: attack and release never overlap, at most one division
    assign off_x25    = 20'(job.offset) * 20'd25;
    assign off_x50    = 20'(job.offset) * 20'd50;
    assign att_region = off_x25 < ATT_LIMIT;
    assign rel_region = off_x50 > REL_LIMIT;
    assign n_att      = 32'(job.offset) * ATT_SCALE;
    assign n_rel      = (32'(NOTE_LENGTH) - 32'(job.offset)) * REL_SCALE;
    assign div_n      = rel_region ? n_rel : n_att;
    assign div_d      = rel_region ? REL_DIV : ATT_DIV;
    assign div_r      = rel_region ? REL_RECIP : ATT_RECIP;
    assign rem        = div_n - mul_p[31:0];
    assign q0_inc     = q0_reg + 16'd1;

    assign gain_w    = sel_reg ? job.bass_gain : job.lead_gain;
    assign mix_abs   = mix_reg[31] ? -mix_reg : mix_reg;
    assign gain_term = {3'd0, mul_p[28:0]};
    assign mix_base  = sel_reg ? mix_reg : 32'sd0;
    assign s_round   = {1'b0, mul_p[61:30]} + Q15_HALF;
    assign v_wide    = s_round[32:15];
    assign scaled    = mul_p[45:30];

    always_comb begin
        case (state_reg)
            C_PROD: begin
                op_a = job.inc;
                op_b = 32'(job.position);
            end
            C_RECIP: begin
                op_a = div_n;
                op_b = div_r;
            end
            C_CORR: begin
                op_a = 32'(q0_reg);
                op_b = div_d;
            end
            C_SQUARE: begin
                op_a = {1'b0, x_w};
                op_b = {1'b0, x_w};
            end
            C_HORNER: begin
                op_a = {1'b0, x2_reg};
                op_b = t_reg;
            end
            C_POLY: begin
                op_a = {1'b0, x_w};
                op_b = t_reg;
            end
            C_GAIN: begin
                op_a = 32'(gain_w);
                op_b = 32'(v_reg);
            end
            C_SCALE: begin
                op_a = {1'b0, mix_abs[30:0]};
                op_b = 32'(env_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        hcnt_next   = hcnt_reg;
        sel_next    = sel_reg;
        prod_next   = prod_reg;
        q0_next     = q0_reg;
        env_next    = env_reg;
        x2_next     = x2_reg;
        t_next      = t_reg;
        v_next      = v_reg;
        mix_next    = mix_reg;
        sample_next = sample_reg;
        done_next   = 1'b0;

        if (state_reg == C_IDLE) begin
            if (start) begin
                state_next = C_PROD;
                phase_next = 1'b0;
            end
        end else if (!phase_reg) begin
            phase_next = 1'b1;
        end else begin
            phase_next = 1'b0;
            case (state_reg)
                C_PROD: begin
                    prod_next  = mul_p[32:0];
                    state_next = C_RECIP;
                end
                C_RECIP: begin
                    q0_next    = mul_p[47:32];
                    state_next = C_CORR;
                end
                C_CORR: begin
                    if (att_region || rel_region) begin
                        env_next = (rem >= div_d) ? q0_inc : q0_reg;
                    end else begin
                        env_next = ENV_ONE;
                    end
                    sel_next   = 1'b0;
                    state_next = C_SQUARE;
                end
                C_SQUARE: begin
                    x2_next    = mul_p[60:30];
                    t_next     = SIN_A9;
                    hcnt_next  = 2'd0;
                    state_next = C_HORNER;
                end
                C_HORNER: begin
                    t_next    = horner_coef(hcnt_reg) - mul_p[61:30];
                    hcnt_next = hcnt_reg + 2'd1;
                    if (hcnt_reg == 2'd3) begin
                        state_next = C_POLY;
                    end
                end
                C_POLY: begin
                    v_next     = (v_wide > 18'(SINE_MAX)) ? SINE_MAX : v_wide[14:0];
                    state_next = C_GAIN;
                end
                C_GAIN: begin
                    mix_next = quad[1] ? (mix_base - gain_term) : (mix_base + gain_term);
                    if (!sel_reg) begin
                        sel_next   = 1'b1;
                        state_next = C_SQUARE;
                    end else begin
                        state_next = C_SCALE;
                    end
                end
                C_SCALE: begin
                    sample_next = mix_reg[31] ? (16'd0 - scaled) : scaled;
                    done_next   = 1'b1;
                    state_next  = C_IDLE;
                end
                default: begin
                    state_next = C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            phase_reg <= 1'b0;
            hcnt_reg  <= 2'd0;
            sel_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            sel_reg   <= sel_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        q0_reg     <= q0_next;
        env_reg    <= env_next;
        x2_reg     <= x2_next;
        t_reg      <= t_next;
        v_reg      <= v_next;
        mix_reg    <= mix_next;
        sample_reg <= sample_next;
    end

    assign done   = done_reg;
    assign sample = sample_reg;

endmodule

// ----- hdl/mcs_checker.sv -----
module mcs_checker
    import mcs_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_stop_request,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [SAMPLE_W-1:0] m_sample,
    input logic                       m_last
);

    // output word holds while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample) && $stable(m_last))
        else $error("output word changed while stalled");

    // one word in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in work");

    // reset leaves the block idle and the output empty
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

    // stop yields a zero sample that ends the run
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_stop_request && !m_valid
        |=> ##1 m_valid && m_last && (m_sample == '0))
        else $error("stop word not answered by a zero last sample");

endmodule

bind melody_chime_synth mcs_checker u_mcs_checker (.*);
